### rtl/plct_pkg.sv
// ----------------------------------------------------------------------------
// plct_pkg
// Shared constants and types for the calibration table block.
// ----------------------------------------------------------------------------
package plct_pkg;

	localparam int NUM_TABLES = 6;
	localparam int NUM_CODES  = 4096;
	localparam int MAX_POINTS = 128;
	localparam int ENERGY_W   = 32;
	localparam int FRAC_W     = 16;

	localparam int CMD_W    = 2;
	localparam int TSEL_W   = 3;
	localparam int IDX_W    = $clog2(MAX_POINTS);
	localparam int CODE_W   = $clog2(NUM_CODES);
	localparam int CNT_W    = $clog2(MAX_POINTS + 1);
	localparam int STAT_W   = 3;
	localparam int SLOPE_W  = ENERGY_W + FRAC_W;
	localparam int ACC_W    = SLOPE_W + CODE_W;
	localparam int PART_W   = ACC_W - FRAC_W;
	localparam int DIVC_W   = $clog2(SLOPE_W);

	localparam int PT_W      = CODE_W + ENERGY_W;
	localparam int PT_DEPTH  = NUM_TABLES * MAX_POINTS;
	localparam int TAB_DEPTH = NUM_TABLES * NUM_CODES;
	localparam int PT_AW     = $clog2(PT_DEPTH);
	localparam int TAB_AW    = $clog2(TAB_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_BUILD  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_FIRST  = 3'd2;
	localparam logic [STAT_W-1:0] ST_CODE_ORDER = 3'd3;
	localparam logic [STAT_W-1:0] ST_EN_ORDER   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_BUILT  = 3'd5;

endpackage

### rtl/plct_ram.sv
// ----------------------------------------------------------------------------
// plct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/piecewise_linear_calib_table.sv
// ----------------------------------------------------------------------------
// piecewise_linear_calib_table
// Calibration point store and per-table ADC-code to energy lookup.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command item: load point,
// build table or look up code. Output channel (out_valid / out_stall)
// returns exactly one result item (status, energy_out) per command.
// Loads and lookups are taken one per cycle while in_stall is low; the
// result passes through the read stage into the output register. Lookups
// read the energy table RAM. A build walks the points of one table through
// the point RAM: per segment one read, one check and a bit-serial slope
// division, then one table write per code; codes past the last point are
// filled up to 4095. During a build in_stall is held high. A bad count or
// table answers without a build. Reset clears all built flags; lookups
// then answer status 5 until a build succeeds. Point and table RAMs are
// not cleared. When out_stall holds the output register, one further item
// can wait in the read stage, after which in_stall rises until the output
// moves again.
// ----------------------------------------------------------------------------
module piecewise_linear_calib_table
	import plct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [TSEL_W-1:0]   table_select,
	input  logic [IDX_W-1:0]    point_index,
	input  logic [CODE_W-1:0]   adc_code,
	input  logic [ENERGY_W-1:0] energy_in,
	input  logic [CNT_W-1:0]    point_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [ENERGY_W-1:0] energy_out
);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CHK, S_DIV, S_FILL, S_EXT, S_DONE
	} state_t;

	state_t state_q;

	logic                  adv, busy, acc_in, t_ok, cnt_ok, start, done_fire;
	logic [NUM_TABLES-1:0] built_q;

	// build registers
	logic [TSEL_W-1:0]   t_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    p_q;
	logic [CODE_W-1:0]   prev_c_q, cur_c_q, dc_q, c_q;
	logic [ENERGY_W-1:0] prev_e_q, cur_e_q;
	logic [SLOPE_W-1:0]  slope_q, dq_q;
	logic [CODE_W-1:0]   rem_q;
	logic [DIVC_W-1:0]   dcnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [STAT_W-1:0]   fsm_st_q;

	// read stage and output register
	logic                s1_v, s1_lk;
	logic [STAT_W-1:0]   s1_status;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [ENERGY_W-1:0] energy_q;

	// memories
	logic                pt_we, pt_re, tab_we, tab_re;
	logic [PT_AW-1:0]    pt_waddr, pt_raddr;
	logic [PT_W-1:0]     pt_wdata, pt_rdata;
	logic [TAB_AW-1:0]   tab_waddr, tab_raddr;
	logic [ENERGY_W-1:0] tab_wdata, tab_rdata;

	logic [CODE_W-1:0]   rd_c;
	logic [ENERGY_W-1:0] rd_e;
	logic [CODE_W:0]     rem_sh;
	logic                q_bit;
	logic [ENERGY_W:0]   line_sum;

	assign adv       = !out_valid_q || !out_stall;
	assign busy      = (state_q != S_IDLE);
	assign in_stall  = busy || (s1_v && !adv);
	assign acc_in    = in_valid && !in_stall;
	assign t_ok      = (table_select < TSEL_W'(NUM_TABLES));
	assign cnt_ok    = (point_count >= CNT_W'(2)) && (point_count <= CNT_W'(MAX_POINTS));
	assign start     = acc_in && (command == CMD_BUILD) && t_ok && cnt_ok;
	assign done_fire = (state_q == S_DONE) && (!s1_v || adv);

	assign {rd_c, rd_e} = pt_rdata;

	// restoring divider step: one quotient bit per cycle
	assign rem_sh = {rem_q, dq_q[SLOPE_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, dc_q});

	// base + floor(slope * k / 2^16), saturated
	assign line_sum  = {1'b0, prev_e_q} + (ENERGY_W+1)'(acc_q[ACC_W-1:FRAC_W]);
	assign tab_wdata = ((acc_q[ACC_W-1:FRAC_W] >> ENERGY_W) != '0 || line_sum[ENERGY_W])
		? '1 : line_sum[ENERGY_W-1:0];

	assign pt_we    = acc_in && (command == CMD_LOAD) && t_ok;
	assign pt_waddr = {table_select, point_index};
	assign pt_wdata = {adc_code, energy_in};
	assign pt_re    = (state_q == S_RD);
	assign pt_raddr = {t_q, p_q[IDX_W-1:0]};

	assign tab_we    = (state_q == S_FILL) || (state_q == S_EXT);
	assign tab_waddr = {t_q, c_q};
	assign tab_re    = acc_in && (command == CMD_LOOKUP);
	assign tab_raddr = {table_select, adc_code};

	plct_ram #(.WIDTH(PT_W), .DEPTH(PT_DEPTH)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	plct_ram #(.WIDTH(ENERGY_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	// build sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			built_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_in && (command == CMD_BUILD) && t_ok) begin
						built_q[table_select] <= 1'b0;
					end
					if (start) begin
						t_q     <= table_select;
						cnt_q   <= point_count;
						p_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (p_q == '0) begin
						if (rd_c != '0 || rd_e != '0) begin
							fsm_st_q <= ST_BAD_FIRST;
							state_q  <= S_DONE;
						end else begin
							prev_c_q <= rd_c;
							prev_e_q <= rd_e;
							p_q      <= CNT_W'(1);
							state_q  <= S_RD;
						end
					end else if (rd_c <= prev_c_q) begin
						fsm_st_q <= ST_CODE_ORDER;
						state_q  <= S_DONE;
					end else if (rd_e <= prev_e_q) begin
						fsm_st_q <= ST_EN_ORDER;
						state_q  <= S_DONE;
					end else begin
						cur_c_q <= rd_c;
						cur_e_q <= rd_e;
						dc_q    <= rd_c - prev_c_q;
						dq_q    <= {rd_e - prev_e_q, {FRAC_W{1'b0}}};
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= q_bit ? CODE_W'(rem_sh - {1'b0, dc_q}) : rem_sh[CODE_W-1:0];
					dq_q   <= {dq_q[SLOPE_W-2:0], q_bit};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIVC_W'(SLOPE_W - 1)) begin
						slope_q <= {dq_q[SLOPE_W-2:0], q_bit};
						acc_q   <= '0;
						c_q     <= prev_c_q;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					acc_q <= acc_q + ACC_W'(slope_q);
					c_q   <= c_q + 1'b1;
					if (c_q + 1'b1 == cur_c_q) begin
						prev_c_q <= cur_c_q;
						prev_e_q <= cur_e_q;
						if (p_q == cnt_q - 1'b1) begin
							acc_q   <= '0;
							c_q     <= cur_c_q;
							state_q <= S_EXT;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_EXT: begin
					acc_q <= acc_q + ACC_W'(slope_q);
					c_q   <= c_q + 1'b1;
					if (c_q == CODE_W'(NUM_CODES - 1)) begin
						built_q[t_q] <= 1'b1;
						fsm_st_q     <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// read stage: holds the item while the table RAM answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (done_fire || (acc_in && !start)) begin
			s1_v <= 1'b1;
		end else if (adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			s1_status <= fsm_st_q;
			s1_lk     <= 1'b0;
		end else if (acc_in) begin
			s1_lk     <= 1'b0;
			s1_status <= ST_OK;
			case (command)
				CMD_BUILD: begin
					s1_status <= t_ok ? ST_BAD_COUNT : ST_NOT_BUILT;
				end
				CMD_LOOKUP: begin
					if (t_ok && built_q[table_select]) begin
						s1_lk <= 1'b1;
					end else begin
						s1_status <= ST_NOT_BUILT;
					end
				end
				default: s1_status <= ST_OK;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= s1_status;
			energy_q <= s1_lk ? tab_rdata : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign energy_out = energy_q;

endmodule
